>>> rtl/otp_pkg.sv
// Shared types and constants of the one-shot timer pool.
// Used by the top level and the port checker; depends on nothing else.
`default_nettype none

package otp_pkg;

   localparam int OTP_SLOTS         = 8;
   localparam int OTP_COUNT_WIDTH   = 16;
   localparam int OTP_MAX_REPORTS   = 8;
   localparam int OTP_REPORT_CNT_W  = 4;
   localparam int OTP_SLOT_FIELD_W  = 3;
   localparam int OTP_DURATION_W    = 16;
   localparam int OTP_HANDLER_W     = 8;
   localparam int OTP_TAG_W         = 8;
   localparam int OTP_REQ_TDATA_W   = 32;
   localparam int OTP_RSP_TDATA_W   = 24;
   localparam int OTP_RSP_PAD_W     = OTP_RSP_TDATA_W - OTP_SLOT_FIELD_W
                                      - OTP_HANDLER_W - OTP_TAG_W;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      EV_STARTED = 2'd0,
      EV_FULL    = 2'd1,
      EV_EXPIRED = 2'd2,
      EV_STOPPED = 2'd3
   } event_type;

endpackage

`default_nettype wire

>>> rtl/otp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module otp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/one_shot_timer_pool_top.sv
// Top level of the one-shot timer pool: sequencer, busy flags, state RAM.
// Depends on otp_pkg and otp_ram.
`default_nettype none

// Pool of SLOTS one-shot timers. Each request beat is a start (tuser 0), a
// tick (tuser 1) or a stop (tuser 2); tuser 3 is dropped with no response.
// One request is worked on at a time and req_tready is low meanwhile. A start
// walks the busy flags one slot per cycle. A tick walks every slot: an idle
// slot is passed over, a busy one gets a read of the state RAM, then one
// shared increment-and-compare step with write-back; a closing step follows.
// Stalls on the response side hold the sequencer while a beat waits for the
// output register.
// Expiries of a tick come out in slot order, the last one with tlast set; at
// most eight are reported, further ones are freed silently. A zero duration
// expires after the count wraps, 2^COUNT_WIDTH ticks later.
module one_shot_timer_pool_top
   import otp_pkg::*;
#(
   parameter int SLOTS       = OTP_SLOTS,
   parameter int COUNT_WIDTH = OTP_COUNT_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // tdata: duration [15:0], handler [23:16], tag [31:24]
   input  wire logic [OTP_REQ_TDATA_W-1:0] req_tdata,
   // tuser: kind [1:0]
   input  wire logic [1:0]                 req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // tdata: slot [2:0], handler_out [10:3], tag_out [18:11], zero [23:19]
   output logic [OTP_RSP_TDATA_W-1:0]      rsp_tdata,
   // tuser: event_res [1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROW_W = 2 * COUNT_WIDTH + OTP_HANDLER_W + OTP_TAG_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_TICK_RD,
      S_TICK_EV,
      S_FLUSH,
      S_STOP
   } state_type;

   state_type                     state_ff, state_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic [SLOTS-1:0]              busy_ff, busy_in;
   logic [OTP_REPORT_CNT_W-1:0]   n_ff, n_in;

   logic [OTP_DURATION_W-1:0]     dur_ff, dur_in;
   logic [OTP_HANDLER_W-1:0]      hnd_ff, hnd_in;
   logic [OTP_TAG_W-1:0]          tag_ff, tag_in;

   logic                          pend_valid_ff, pend_valid_in;
   logic [IW-1:0]                 pend_slot_ff, pend_slot_in;
   logic [OTP_HANDLER_W-1:0]      pend_hnd_ff, pend_hnd_in;
   logic [OTP_TAG_W-1:0]          pend_tag_ff, pend_tag_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   event_type                     rsp_event_ff, rsp_event_in;
   logic [OTP_SLOT_FIELD_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [OTP_HANDLER_W-1:0]      rsp_hnd_ff, rsp_hnd_in;
   logic [OTP_TAG_W-1:0]          rsp_tag_ff, rsp_tag_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          ram_we;
   logic [ROW_W-1:0]              ram_wdata;
   logic [ROW_W-1:0]              ram_rdata;

   logic [COUNT_WIDTH-1:0]        row_elapsed;
   logic [COUNT_WIDTH-1:0]        row_limit;
   logic [OTP_HANDLER_W-1:0]      row_hnd;
   logic [OTP_TAG_W-1:0]          row_tag;
   logic [COUNT_WIDTH-1:0]        elap_next;
   logic                          hit;
   logic                          out_free;
   logic                          idx_last;
   logic                          need_push;

   // state row: elapsed, limit, handler, tag
   otp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign {row_elapsed, row_limit, row_hnd, row_tag} = ram_rdata;

   // shared increment-and-compare unit
   assign elap_next = row_elapsed + COUNT_WIDTH'(1);
   assign hit       = (elap_next == row_limit);

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign idx_last  = (idx_ff == IW'(SLOTS - 1));
   assign need_push = hit && (n_ff < OTP_REPORT_CNT_W'(OTP_MAX_REPORTS)) && pend_valid_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      busy_in       = busy_ff;
      n_in          = n_ff;
      dur_in        = dur_ff;
      hnd_in        = hnd_ff;
      tag_in        = tag_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_hnd_in   = pend_hnd_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_event_in  = rsp_event_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_wdata     = {elap_next, row_limit, row_hnd, row_tag};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dur_in        = req_tdata[15:0];
               hnd_in        = req_tdata[23:16];
               tag_in        = req_tdata[31:24];
               idx_in        = '0;
               n_in          = '0;
               pend_valid_in = 1'b0;
               case (kind_type'(req_tuser))
                  KIND_START: state_in = S_START;
                  KIND_TICK:  state_in = S_TICK_RD;
                  KIND_STOP:  state_in = S_STOP;
                  default:    state_in = S_IDLE;
               endcase
            end
         end

         S_START: begin
            if (!busy_ff[idx_ff]) begin
               if (out_free) begin
                  ram_we           = 1'b1;
                  ram_wdata        = {COUNT_WIDTH'(0), COUNT_WIDTH'(dur_ff), hnd_ff, tag_ff};
                  busy_in[idx_ff]  = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_event_in     = EV_STARTED;
                  rsp_slot_in      = OTP_SLOT_FIELD_W'(idx_ff);
                  rsp_hnd_in       = '0;
                  rsp_tag_in       = '0;
                  rsp_last_in      = 1'b1;
                  state_in         = S_IDLE;
               end
            end else if (idx_last) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_event_in = EV_FULL;
                  rsp_slot_in  = '0;
                  rsp_hnd_in   = '0;
                  rsp_tag_in   = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         S_TICK_RD: begin
            // read data for this slot shows up next cycle
            if (busy_ff[idx_ff]) begin
               state_in = S_TICK_EV;
            end else if (idx_last) begin
               state_in = S_FLUSH;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         S_TICK_EV: begin
            // hold here while an earlier expiry waits for the output register
            if (!need_push || out_free) begin
               ram_we = 1'b1;
               if (hit) begin
                  busy_in[idx_ff] = 1'b0;
                  if (n_ff < OTP_REPORT_CNT_W'(OTP_MAX_REPORTS)) begin
                     n_in          = n_ff + OTP_REPORT_CNT_W'(1);
                     pend_valid_in = 1'b1;
                     pend_slot_in  = idx_ff;
                     pend_hnd_in   = row_hnd;
                     pend_tag_in   = row_tag;
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_event_in = EV_EXPIRED;
                        rsp_slot_in  = OTP_SLOT_FIELD_W'(pend_slot_ff);
                        rsp_hnd_in   = pend_hnd_ff;
                        rsp_tag_in   = pend_tag_ff;
                        rsp_last_in  = 1'b0;
                     end
                  end
               end
               if (idx_last) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_TICK_RD;
               end
            end
         end

         S_FLUSH: begin
            // the held expiry is the final beat of this tick
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_event_in  = EV_EXPIRED;
               rsp_slot_in   = OTP_SLOT_FIELD_W'(pend_slot_ff);
               rsp_hnd_in    = pend_hnd_ff;
               rsp_tag_in    = pend_tag_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_STOP: begin
            if (out_free) begin
               busy_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_event_in = EV_STOPPED;
               rsp_slot_in  = '0;
               rsp_hnd_in   = '0;
               rsp_tag_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dur_ff       <= dur_in;
      hnd_ff       <= hnd_in;
      tag_ff       <= tag_in;
      pend_slot_ff <= pend_slot_in;
      pend_hnd_ff  <= pend_hnd_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_event_ff <= rsp_event_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_hnd_ff   <= rsp_hnd_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         busy_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         busy_ff       <= busy_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {OTP_RSP_PAD_W'(0), rsp_tag_ff, rsp_hnd_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/otp_checker.sv
// Port-level checks of the one-shot timer pool, bound to the top level.
// Depends on otp_pkg.
`default_nettype none

module otp_checker
   import otp_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic [1:0]                 req_tuser,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [OTP_RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]                 rsp_tuser,
   input wire logic                       rsp_tlast
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // a start, tick or stop request leaves req_tready low in the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
         ((req_tuser == KIND_START) || (req_tuser == KIND_TICK) ||
          (req_tuser == KIND_STOP)) |=> !req_tready)
      else $error("request taken while previous one in progress");

   // only expiries can be non-final beats
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != EV_EXPIRED) |-> rsp_tlast)
      else $error("single-beat response without tlast");

   // handler and tag are zero unless a timer expired; padding is always zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:19] == 5'd0) &&
         ((rsp_tuser == EV_EXPIRED) || (rsp_tdata[18:3] == 16'd0)))
      else $error("nonzero handler or tag on a non-expiry beat");

   // full and stop reports name slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == EV_FULL) || (rsp_tuser == EV_STOPPED)) |->
         (rsp_tdata[2:0] == 3'd0))
      else $error("full or stop report with nonzero slot");

endmodule

bind one_shot_timer_pool_top otp_checker u_otp_checker (.*);

`default_nettype wire

>>> test/tb_one_shot_timer_pool_top.sv
// Self-checking testbench for one_shot_timer_pool_top: it drives start, tick and stop
// beats, predicts every report of the pool and compares the responses field by field.
// Depends on otp_pkg and the RTL of the top level; needs no files or arguments.
`timescale 1ns / 100ps

module tb_one_shot_timer_pool_top;
   import otp_pkg::*;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_CMDS  = 270;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         LONG_HOLD    = 400;
   localparam int         SETTLE_TIME  = 4 * OTP_SLOTS + 8;

   typedef struct {
      logic [1:0]                kind;
      logic [OTP_DURATION_W-1:0] duration;
      logic [OTP_HANDLER_W-1:0]  handler;
      logic [OTP_TAG_W-1:0]      tag;
      bit                        wait_idle;     // hold until every report is back
      bit                        back_to_back;  // no gap after this beat
   } timer_cmd_type;

   typedef struct {
      event_type                      ev;
      logic [OTP_SLOT_FIELD_W-1:0]    slot;
      logic [OTP_HANDLER_W-1:0]       handler;
      logic [OTP_TAG_W-1:0]           tag;
      logic                           last;
   } timer_report_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [OTP_REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]                 req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [OTP_RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]                 rsp_tuser;
   logic                       rsp_tlast;

   // predicted pool state
   logic                       slot_busy    [OTP_SLOTS];
   logic [OTP_COUNT_WIDTH-1:0] slot_count   [OTP_SLOTS];
   logic [OTP_COUNT_WIDTH-1:0] slot_limit   [OTP_SLOTS];
   logic [OTP_HANDLER_W-1:0]   slot_handler [OTP_SLOTS];
   logic [OTP_TAG_W-1:0]       slot_tag     [OTP_SLOTS];

   timer_cmd_type    timer_cmds[$];
   timer_report_type owed_reports[$];
   timer_cmd_type    cmd_in_flight;

   int send_gap      = 0;
   int send_calm     = 0;
   int recv_hold     = 0;
   int recv_calm     = 0;
   bit long_hold_done = 1'b0;
   int quiet_cycles  = 0;
   int cmds_accepted = 0;
   int reports_seen  = 0;
   int mismatch_count = 0;
   int starts_seen   = 0;
   int refusals_seen = 0;
   int expiries_seen = 0;
   int stops_seen    = 0;

   one_shot_timer_pool_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic timer_cmd_type make_cmd(logic [1:0] kind, logic [15:0] duration,
                                              logic [7:0] handler, logic [7:0] tag);
      timer_cmd_type cmd;
      cmd.kind         = kind;
      cmd.duration     = duration;
      cmd.handler      = handler;
      cmd.tag          = tag;
      cmd.wait_idle    = 1'b0;
      cmd.back_to_back = 1'b0;
      return cmd;
   endfunction

   // Apply one accepted command to the predicted pool and queue the reports it owes.
   function automatic void advance_timer_model(timer_cmd_type cmd);
      timer_report_type rep;
      logic             fired [OTP_SLOTS];
      int               claimed;
      int               last_fired;
      int               n_fired;
      claimed     = -1;
      last_fired  = -1;
      n_fired     = 0;
      rep.ev      = EV_STARTED;
      rep.slot    = '0;
      rep.handler = '0;
      rep.tag     = '0;
      rep.last    = 1'b1;
      case (cmd.kind)
         KIND_START: begin
            for (int s = OTP_SLOTS - 1; s >= 0; s--)
               if (!slot_busy[s]) claimed = s;
            if (claimed < 0) begin
               rep.ev = EV_FULL;
            end else begin
               slot_busy[claimed]    = 1'b1;
               slot_count[claimed]   = '0;
               slot_limit[claimed]   = OTP_COUNT_WIDTH'(cmd.duration);
               slot_handler[claimed] = cmd.handler;
               slot_tag[claimed]     = cmd.tag;
               rep.slot              = OTP_SLOT_FIELD_W'(claimed);
            end
            owed_reports.push_back(rep);
         end
         KIND_TICK: begin
            for (int s = 0; s < OTP_SLOTS; s++) begin
               fired[s] = 1'b0;
               if (slot_busy[s]) begin
                  slot_count[s] = slot_count[s] + 1'b1;
                  if (slot_count[s] == slot_limit[s]) begin
                     fired[s]      = 1'b1;
                     slot_busy[s]  = 1'b0;
                     slot_count[s] = '0;
                     if (n_fired < OTP_MAX_REPORTS) last_fired = s;
                     n_fired++;
                  end
               end
            end
            // report the first expiries in slot order, drop the rest silently
            n_fired = 0;
            for (int s = 0; s < OTP_SLOTS; s++) begin
               if (fired[s] && n_fired < OTP_MAX_REPORTS) begin
                  rep.ev      = EV_EXPIRED;
                  rep.slot    = OTP_SLOT_FIELD_W'(s);
                  rep.handler = slot_handler[s];
                  rep.tag     = slot_tag[s];
                  rep.last    = (s == last_fired);
                  owed_reports.push_back(rep);
                  n_fired++;
               end
            end
         end
         KIND_STOP: begin
            for (int s = 0; s < OTP_SLOTS; s++) slot_busy[s] = 1'b0;
            rep.ev = EV_STOPPED;
            owed_reports.push_back(rep);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Request side: offer queued commands, predict at acceptance.
   always @(posedge clock) begin
      timer_cmd_type next_cmd;
      int            roll;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_timer_model(cmd_in_flight);
            cmds_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (timer_cmds.size() > 0 &&
                         !(timer_cmds[0].wait_idle && owed_reports.size() > 0)) begin
               next_cmd = timer_cmds.pop_front();
               cmd_in_flight <= next_cmd;
               req_tuser     <= next_cmd.kind;
               req_tdata     <= {next_cmd.tag, next_cmd.handler, next_cmd.duration};
               req_tvalid    <= 1'b1;
               roll = $urandom_range(99);
               if (next_cmd.back_to_back || send_calm > 0 || roll < 55) begin
                  send_gap <= 0;
               end else if (roll < 90) begin
                  send_gap <= $urandom_range(1, 3);
               end else begin
                  send_gap <= $urandom_range(8, 40);
               end
               if (send_calm > 0) begin
                  send_calm <= send_calm - 1;
               end else if ($urandom_range(29) == 0) begin
                  send_calm <= $urandom_range(20, 60);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side backpressure, with one long hold-off once traffic is flowing.
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold  <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && reports_seen >= 40) begin
         long_hold_done <= 1'b1;
         recv_hold      <= LONG_HOLD;
         rsp_tready     <= 1'b0;
      end else if (recv_calm > 0) begin
         recv_calm  <= recv_calm - 1;
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            recv_calm  <= $urandom_range(20, 80);
            rsp_tready <= 1'b1;
         end else if (roll < 20) begin
            recv_hold  <= $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else if (roll < 23) begin
            recv_hold  <= $urandom_range(8, 40);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each accepted response beat with the oldest owed report.
   always @(posedge clock) begin
      timer_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         case (rsp_tuser)
            EV_STARTED: starts_seen++;
            EV_FULL:    refusals_seen++;
            EV_EXPIRED: expiries_seen++;
            default:    stops_seen++;
         endcase
         if (owed_reports.size() == 0) begin
            $error("unexpected response beat: event %0d slot %0d", rsp_tuser, rsp_tdata[2:0]);
            mismatch_count++;
         end else begin
            want = owed_reports.pop_front();
            check_field("event_res", want.ev, rsp_tuser);
            check_field("slot", want.slot, rsp_tdata[2:0]);
            check_field("handler_out", want.handler, rsp_tdata[10:3]);
            check_field("tag_out", want.tag, rsp_tdata[18:11]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      timer_cmd_type cmd;
      int            n_rand;
      int            pick;
      logic [15:0]   dur;
      for (int s = 0; s < OTP_SLOTS; s++) begin
         slot_busy[s]    = 1'b0;
         slot_count[s]   = '0;
         slot_limit[s]   = '0;
         slot_handler[s] = '0;
         slot_tag[s]     = '0;
      end

      // fill the pool with one-tick timers, overflow it, expire all at once
      for (int s = 0; s < OTP_SLOTS; s++)
         timer_cmds.push_back(make_cmd(KIND_START, 16'd1, 8'(s * 37), ~8'(s * 37)));
      timer_cmds.push_back(make_cmd(KIND_START, 16'hFFFF, 8'hFF, 8'hFF));
      timer_cmds.push_back(make_cmd(KIND_TICK, 16'h0000, 8'h00, 8'h00));
      timer_cmds.push_back(make_cmd(KIND_TICK, 16'hFFFF, 8'hFF, 8'hFF));
      timer_cmds.push_back(make_cmd(KIND_UNUSED, 16'hFFFF, 8'hFF, 8'hFF));
      timer_cmds.push_back(make_cmd(KIND_START, 16'd2, 8'hA5, 8'h5A));
      timer_cmds.push_back(make_cmd(KIND_START, 16'hFFFF, 8'h5A, 8'hA5));
      timer_cmds.push_back(make_cmd(KIND_TICK, 16'h1234, 8'h00, 8'h00));
      timer_cmds.push_back(make_cmd(KIND_STOP, 16'hFFFF, 8'hFF, 8'hFF));
      timer_cmds.push_back(make_cmd(KIND_TICK, 16'h0000, 8'h00, 8'h00));
      // freed slot counts must restart from zero
      timer_cmds.push_back(make_cmd(KIND_START, 16'd1, 8'h3C, 8'hC3));
      timer_cmds.push_back(make_cmd(KIND_TICK, 16'h0000, 8'h00, 8'h00));
      timer_cmds.push_back(make_cmd(KIND_STOP, 16'h0000, 8'h00, 8'h00));

      // random traffic, alternating between filling and draining the pool
      n_rand = 0;
      while (n_rand < RANDOM_CMDS) begin
         cmd  = make_cmd(KIND_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
         pick = $urandom_range(99);
         if (pick < 5) begin
            cmd.kind = KIND_UNUSED;
         end else if (pick < 10) begin
            cmd.kind = KIND_STOP;
         end else if (pick < (((n_rand / 40) % 2 == 0) ? 65 : 35)) begin
            cmd.kind = KIND_START;
            pick = $urandom_range(99);
            if (pick < 5) begin
               dur = 16'd0;
            end else if (pick < 15) begin
               dur = 16'($urandom);
            end else begin
               dur = 16'($urandom_range(1, 12));
            end
            cmd.duration = dur;
         end
         if (cmd.kind != KIND_UNUSED) begin
            if (n_rand == RANDOM_CMDS / 2) cmd.wait_idle = 1'b1;
            n_rand++;
         end
         timer_cmds.push_back(cmd);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (timer_cmds.size() > 0 || req_tvalid || owed_reports.size() > 0)
         @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);

      $display("Run covered %0d commands with fill, overflow, mass expiry and stop traffic:",
               cmds_accepted);
      $display("  %0d starts, %0d pool-full refusals, %0d expiries, %0d stop acks",
               starts_seen, refusals_seen, expiries_seen, stops_seen);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
